FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL of the packet classifier.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside of reset.
`define ASSERT_CLKD(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge outside of reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

FILE: rtl/ipcp_pkg.sv
// ----------------------------------------------------------------------------
// ipcp_pkg
// Codes, offsets and record types of the IP packet class parser.
// ----------------------------------------------------------------------------
package ipcp_pkg;

    // Result class codes.
    localparam logic [3:0] CLS_NONE = 4'd0;
    localparam logic [3:0] CLS_TCP  = 4'd1;
    localparam logic [3:0] CLS_SYN  = 4'd2;
    localparam logic [3:0] CLS_ACK  = 4'd3;
    localparam logic [3:0] CLS_FTP  = 4'd4;
    localparam logic [3:0] CLS_UDP  = 4'd5;
    localparam logic [3:0] CLS_DNS  = 4'd6;
    localparam logic [3:0] CLS_MIP  = 4'd7;
    localparam logic [3:0] CLS_ICMP = 4'd8;
    localparam logic [3:0] CLS_HIGH = 4'd9;
    localparam logic [3:0] CLS_BAD  = 4'd10;

    // Configuration register indexes.
    localparam logic [1:0] REG_FTP_PORT = 2'd0;
    localparam logic [1:0] REG_DNS_PORT = 2'd1;
    localparam logic [1:0] REG_MIP_PORT = 2'd2;

    // Configuration reset values.
    localparam logic [15:0] FTP_PORT_RST = 16'd21;
    localparam logic [15:0] DNS_PORT_RST = 16'd53;
    localparam logic [15:0] MIP_PORT_RST = 16'd434;

    // IP version nibbles and protocol numbers.
    localparam logic [3:0] VER_IPV4 = 4'h4;
    localparam logic [3:0] VER_IPV6 = 4'h6;
    localparam logic [7:0] PROTO_ICMP4 = 8'd1;
    localparam logic [7:0] PROTO_TCP   = 8'd6;
    localparam logic [7:0] PROTO_UDP   = 8'd17;
    localparam logic [7:0] PROTO_ICMP6 = 8'd58;

    // ICMP message types that count as echo traffic.
    localparam logic [7:0] ICMP4_ECHO_REPLY = 8'd0;
    localparam logic [7:0] ICMP4_ECHO_REQ   = 8'd8;
    localparam logic [7:0] ICMP6_ECHO_REQ   = 8'd128;
    localparam logic [7:0] ICMP6_ECHO_REPLY = 8'd129;

    // Lengths and limits.
    localparam logic [15:0] MIN_LEN_EXCL = 16'd20;
    localparam logic [5:0]  V6_HDR_LEN   = 6'd40;
    localparam logic [6:0]  TCP_MIN_HDR  = 7'd20;
    localparam logic [6:0]  UDP_HDR      = 7'd8;
    localparam logic [6:0]  ICMP_HDR     = 7'd8;
    localparam logic [15:0] COUNT_MAX    = 16'hFFFF;
    localparam logic [5:0]  TCP_FLAG_MASK = 6'h3F;
    localparam int unsigned TCP_SYN_BIT  = 1;
    localparam int unsigned TCP_ACK_BIT  = 4;

    // Header fields gathered while a packet streams past.
    typedef struct packed {
        logic [7:0]  ver_ihl;
        logic [15:0] len_field;
        logic [7:0]  proto;
        logic [12:0] frag;
        logic [15:0] dst_port;
        logic [15:0] udp_len;
        logic [3:0]  tcp_off;
        logic [5:0]  tcp_flags;
        logic [7:0]  icmp_type;
    } ipcp_fields_t;

    // Finished packet handed to the classification stage.
    typedef struct packed {
        ipcp_fields_t f;
        logic [15:0]  pkt_len;
        logic         high;
    } ipcp_snap_t;

endpackage

FILE: rtl/ip_packet_class_parser.sv
// ----------------------------------------------------------------------------
// ip_packet_class_parser
// Byte-serial IPv4/IPv6 header parser that gives one traffic class per packet.
// ----------------------------------------------------------------------------
// The packet enters one byte per request on the s_ channel, starting at the IP
// header; s_tlast marks the final byte and s_tuser carries the caller's
// high-priority flag, which is only looked at together with s_tlast.
// Each request updates a byte counter (saturating at 65535) and the captured
// header fields, so a new byte can be taken in every cycle while s_tready is high.
// On the last byte the captured fields are copied into a snapshot register and
// the per-packet state is cleared, so the next packet may start in the very
// next cycle. The snapshot is then classified into the output register as soon
// as that register is free, and the result is offered on the m_ channel from
// there; one result leaves per packet.
// The m_ channel holds its request while m_tready is low. The snapshot stage
// keeps taking bytes during such a stall; only when both the snapshot and the
// output register hold an unsent packet does s_tready drop.
// The cfg channel writes the three port registers and is always ready; writes
// belong to idle periods. Reset (aresetn low at a clock edge) restores the
// port registers to 21, 53 and 434, clears the packet state and empties both
// stages.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ip_packet_class_parser
    import ipcp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,

    // Packet byte stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] data_byte
    input  logic        s_tlast,     // byte_last
    input  logic        s_tuser,     // high_priority

    // Classification results.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata      // [3:0] packet_class, [9:4] ip_header_len,
                                     // [25:10] ip_total_len, [31:26] zero
);

    // Configuration registers.
    logic [15:0] ftp_port_reg;
    logic [15:0] dns_port_reg;
    logic [15:0] mip_port_reg;

    // Per-packet state.
    logic [15:0]  byte_count_reg;
    logic [15:0]  byte_count_next;
    ipcp_fields_t fields_reg;
    ipcp_fields_t fields_next;

    // Snapshot stage.
    ipcp_snap_t   snap_reg;
    logic         snap_valid_reg;

    // Output register.
    logic         m_tvalid_reg;
    logic [3:0]   out_class_reg;
    logic [5:0]   out_hl_reg;
    logic [15:0]  out_tl_reg;

    logic         s_accept;
    logic         out_open;

    // Capture-side helpers.
    logic [7:0]   vb;
    logic         cap_v4;
    logic         cap_v6;
    logic [6:0]   cap_hl;
    logic [6:0]   off_p2, off_p3, off_p4, off_p5, off_p12, off_p13;

    // Classification results.
    logic [3:0]   cls_class;
    logic [5:0]   cls_hl;
    logic [15:0]  cls_tl;

    assign cfg_ready = 1'b1;

    // The output register can load when it is empty or is being emptied.
    assign out_open = !m_tvalid_reg || m_tready;
    assign s_tready = !snap_valid_reg || out_open;
    assign s_accept = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ftp_port_reg <= FTP_PORT_RST;
            dns_port_reg <= DNS_PORT_RST;
            mip_port_reg <= MIP_PORT_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_FTP_PORT: ftp_port_reg <= cfg_data;
                REG_DNS_PORT: dns_port_reg <= cfg_data;
                REG_MIP_PORT: mip_port_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Field capture for the current byte
    // ------------------------------------------------------------------
    // The version byte is the incoming byte itself at offset zero, so the
    // offsets that depend on the header length are right from the start.
    always_comb begin
        vb     = (byte_count_reg == 16'd0) ? s_tdata : fields_reg.ver_ihl;
        cap_v4 = (vb[7:4] == VER_IPV4);
        cap_v6 = (vb[7:4] == VER_IPV6);
        if (cap_v4) begin
            cap_hl = {1'b0, vb[3:0], 2'b00};
        end else if (cap_v6) begin
            cap_hl = {1'b0, V6_HDR_LEN};
        end else begin
            cap_hl = 7'd0;
        end
        off_p2  = cap_hl + 7'd2;
        off_p3  = cap_hl + 7'd3;
        off_p4  = cap_hl + 7'd4;
        off_p5  = cap_hl + 7'd5;
        off_p12 = cap_hl + 7'd12;
        off_p13 = cap_hl + 7'd13;

        fields_next = fields_reg;
        if (byte_count_reg == 16'd0) begin
            fields_next.ver_ihl = s_tdata;
        end
        if (cap_v4) begin
            if (byte_count_reg == 16'd2) fields_next.len_field[15:8] = s_tdata;
            if (byte_count_reg == 16'd3) fields_next.len_field[7:0]  = s_tdata;
            if (byte_count_reg == 16'd9) fields_next.proto           = s_tdata;
        end else if (cap_v6) begin
            if (byte_count_reg == 16'd4) fields_next.len_field[15:8] = s_tdata;
            if (byte_count_reg == 16'd5) fields_next.len_field[7:0]  = s_tdata;
            if (byte_count_reg == 16'd6) fields_next.proto           = s_tdata;
        end
        // The fragment offset always comes from bytes six and seven.
        if (byte_count_reg == 16'd6) fields_next.frag[12:8] = s_tdata[4:0];
        if (byte_count_reg == 16'd7) fields_next.frag[7:0]  = s_tdata;

        if (cap_v4 || cap_v6) begin
            if (byte_count_reg == {9'd0, cap_hl}) fields_next.icmp_type = s_tdata;
            if (byte_count_reg == {9'd0, off_p2}) fields_next.dst_port[15:8] = s_tdata;
            if (byte_count_reg == {9'd0, off_p3}) fields_next.dst_port[7:0]  = s_tdata;
            if (byte_count_reg == {9'd0, off_p4}) fields_next.udp_len[15:8]  = s_tdata;
            if (byte_count_reg == {9'd0, off_p5}) fields_next.udp_len[7:0]   = s_tdata;
            if (byte_count_reg == {9'd0, off_p12}) fields_next.tcp_off = s_tdata[7:4];
            if (byte_count_reg == {9'd0, off_p13}) begin
                fields_next.tcp_flags = s_tdata[5:0] & TCP_FLAG_MASK;
            end
        end

        byte_count_next = (byte_count_reg == COUNT_MAX) ? byte_count_reg
                                                        : byte_count_reg + 16'd1;
    end

    // Per-packet state: cleared after every last byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= '0;
            fields_reg     <= '0;
        end else if (s_accept) begin
            if (s_tlast) begin
                byte_count_reg <= '0;
                fields_reg     <= '0;
            end else begin
                byte_count_reg <= byte_count_next;
                fields_reg     <= fields_next;
            end
        end
    end

    // Snapshot of a finished packet.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snap_valid_reg <= 1'b0;
        end else if (s_accept && s_tlast) begin
            snap_valid_reg <= 1'b1;
        end else if (out_open) begin
            snap_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && s_tlast) begin
            snap_reg.f       <= fields_next;
            snap_reg.pkt_len <= byte_count_next;
            snap_reg.high    <= s_tuser;
        end
    end

    // ------------------------------------------------------------------
    // Classification of the snapshot
    // ------------------------------------------------------------------
    logic        k_v4, k_v6;
    logic [5:0]  k_hl;
    logic [15:0] k_tl;
    logic [15:0] k_len;
    logic [6:0]  k_hl_thl;
    logic [6:0]  k_hl_tcp;
    logic [6:0]  k_hl_8;

    always_comb begin
        k_v4  = (snap_reg.f.ver_ihl[7:4] == VER_IPV4);
        k_v6  = (snap_reg.f.ver_ihl[7:4] == VER_IPV6);
        k_len = snap_reg.pkt_len;
        k_hl  = k_v4 ? {snap_reg.f.ver_ihl[3:0], 2'b00} : V6_HDR_LEN;
        // IPv6 carries the payload length; the total wraps at sixteen bits.
        k_tl  = k_v4 ? snap_reg.f.len_field
                     : snap_reg.f.len_field + {10'd0, V6_HDR_LEN};
        k_hl_thl = {1'b0, k_hl} + {1'b0, snap_reg.f.tcp_off, 2'b00};
        k_hl_tcp = {1'b0, k_hl} + TCP_MIN_HDR;
        k_hl_8   = {1'b0, k_hl} + UDP_HDR;

        cls_hl    = k_hl;
        cls_tl    = k_tl;
        cls_class = CLS_NONE;

        if (k_len <= MIN_LEN_EXCL || !(k_v4 || k_v6)) begin
            cls_class = CLS_BAD;
            cls_hl    = '0;
            cls_tl    = '0;
        end else if (snap_reg.high) begin
            cls_class = CLS_HIGH;
        end else if (k_len < k_tl || k_tl < {10'd0, k_hl}) begin
            cls_class = CLS_BAD;
        end else begin
            case (snap_reg.f.proto)
                PROTO_TCP: begin
                    if (k_len < {9'd0, k_hl_tcp} || k_len < {9'd0, k_hl_thl}) begin
                        cls_class = CLS_BAD;
                    end else if (k_tl == {9'd0, k_hl_thl}) begin
                        // Bare segment without payload: flags decide.
                        if (snap_reg.f.tcp_flags[TCP_SYN_BIT]) begin
                            cls_class = CLS_SYN;
                        end else if (snap_reg.f.tcp_flags[TCP_ACK_BIT]) begin
                            cls_class = CLS_ACK;
                        end else begin
                            cls_class = CLS_TCP;
                        end
                    end else if (snap_reg.f.dst_port == ftp_port_reg) begin
                        cls_class = CLS_FTP;
                    end else begin
                        cls_class = CLS_TCP;
                    end
                end
                PROTO_UDP: begin
                    if (k_len < {9'd0, k_hl_8} ||
                        snap_reg.f.udp_len < {9'd0, UDP_HDR}) begin
                        cls_class = CLS_BAD;
                    end else if (snap_reg.f.dst_port == mip_port_reg) begin
                        // Mobile IP wins when both ports match.
                        cls_class = CLS_MIP;
                    end else if (snap_reg.f.dst_port == dns_port_reg) begin
                        cls_class = CLS_DNS;
                    end else begin
                        cls_class = CLS_UDP;
                    end
                end
                PROTO_ICMP4: begin
                    if (k_len < {9'd0, k_hl_8}) begin
                        cls_class = CLS_BAD;
                    end else if (snap_reg.f.frag != 13'd0) begin
                        cls_class = CLS_NONE;
                    end else if (snap_reg.f.icmp_type inside
                                 {ICMP4_ECHO_REQ, ICMP4_ECHO_REPLY}) begin
                        cls_class = CLS_ICMP;
                    end else begin
                        cls_class = CLS_NONE;
                    end
                end
                PROTO_ICMP6: begin
                    if (k_len < {9'd0, k_hl_8}) begin
                        cls_class = CLS_BAD;
                    end else if (snap_reg.f.icmp_type inside
                                 {ICMP6_ECHO_REQ, ICMP6_ECHO_REPLY}) begin
                        cls_class = CLS_ICMP;
                    end else begin
                        cls_class = CLS_NONE;
                    end
                end
                default: cls_class = CLS_NONE;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_open) begin
            m_tvalid_reg <= snap_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_open && snap_valid_reg) begin
            out_class_reg <= cls_class;
            out_hl_reg    <= cls_hl;
            out_tl_reg    <= cls_tl;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, out_tl_reg, out_hl_reg, out_class_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A classified snapshot must land in the output register.
    `ASSERT_CLKD(a_snap_to_out, aclk, aresetn,
                 snap_valid_reg && out_open |=> m_tvalid_reg,
                 "classified packet did not reach the output register")
    // The last byte of a packet restarts the byte counter.
    `ASSERT_CLKD(a_last_clears, aclk, aresetn,
                 s_accept && s_tlast |=> byte_count_reg == 16'd0,
                 "byte counter not cleared after the last byte")
    // A middle byte advances the counter by one until it saturates.
    `ASSERT_CLKD(a_count_step, aclk, aresetn,
                 s_accept && !s_tlast && byte_count_reg != COUNT_MAX
                 |=> byte_count_reg == $past(byte_count_reg) + 16'd1,
                 "byte counter did not advance")
    // Input stalls only with both result stages holding unsent packets.
    `ASSERT_NEVER(a_stall_cause, aclk, aresetn,
                  !s_tready && !(snap_valid_reg && m_tvalid_reg),
                  "input stalled without a full result path")

endmodule

FILE: tb/sv/ip_packet_class_parser_tb.sv
// ----------------------------------------------------------------------------
// ip_packet_class_parser_tb
// Self-checking bench for the byte-serial IP packet class parser.
// ----------------------------------------------------------------------------
// Whole packets are built from header descriptions, turned into byte requests
// and queued for a clocked driver. The driver mirrors every accepted byte into
// a local copy of the parser's capture and class logic. That copy turns each
// last byte into an expected class record. A clocked monitor compares every
// result request with the oldest expected record, field by field. The port
// registers are rewritten between phases while the parser is idle. Each phase
// uses a different mix of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module ip_packet_class_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ipcp_pkg::*;

    // One byte request as it travels on the s_ channel.
    typedef struct packed {
        logic       high;
        logic       last;
        logic [7:0] data;
    } stream_item_t;

    // One classification record, laid out as in m_tdata[25:0].
    typedef struct packed {
        logic [15:0] tot_len;
        logic [5:0]  hdr_len;
        logic [3:0]  cls;
    } pkt_result_t;

    // Description of one packet to send. Fields that land outside the packet
    // are simply dropped, so short and odd packets come from the same recipe.
    typedef struct packed {
        logic [3:0]  ver;
        logic [3:0]  ihl;
        logic [7:0]  proto;
        logic [12:0] frag;
        logic [15:0] dport;
        logic [15:0] udp_len;
        logic [3:0]  tcp_off;
        logic [7:0]  tcp_flags;
        logic [7:0]  icmp_type;
        int          n_bytes;
        int          len_adj;
        logic        high;
    } pkt_desc_t;

    localparam int HOLD_OFF_CYCLES = 200;
    localparam int DRAIN_CYCLES    = 8;

    // ------------------------------------------------------------------------
    // Clock, reset and the ports of the parser. Every input starts at a known
    // value before the first clock edge.
    // ------------------------------------------------------------------------
    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_FTP_PORT;
    logic [15:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;   // [7:0] data_byte
    logic        s_tlast   = 1'b0; // byte_last
    logic        s_tuser   = 1'b0; // high_priority
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;          // [3:0] packet_class, [9:4] ip_header_len,
                                   // [25:10] ip_total_len, [31:26] zero

    always #5ns aclk = ~aclk;

    ip_packet_class_parser dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // ------------------------------------------------------------------------
    // Bench state.
    // ------------------------------------------------------------------------
    stream_item_t byte_stream_q[$];     // byte requests waiting for the driver
    pkt_result_t  expected_class_q[$];  // class records still owed by the parser
    logic [7:0]   pkt_buf[$];           // packet under construction

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    logic        hold_off       = 1'b0;
    bit          pressure_go    = 1'b0;

    int unsigned error_count     = 0;
    int unsigned packets_sent    = 0;
    int unsigned bytes_queued    = 0;
    int unsigned bytes_accepted  = 0;
    int unsigned results_checked = 0;
    int unsigned class_seen[16];

    // Local copy of the parser's registers and per-packet capture state.
    logic [15:0]  ftp_port = FTP_PORT_RST;
    logic [15:0]  dns_port = DNS_PORT_RST;
    logic [15:0]  mip_port = MIP_PORT_RST;
    ipcp_fields_t hdr_fields = '0;
    logic [15:0]  byte_cnt   = '0;

    // ------------------------------------------------------------------------
    // Class prediction.
    // ------------------------------------------------------------------------

    // Header length implied by the first byte; zero for an unknown version.
    function automatic int unsigned header_bytes(logic [7:0] vb);
        if (vb[7:4] == VER_IPV4) return {vb[3:0], 2'b00};
        if (vb[7:4] == VER_IPV6) return V6_HDR_LEN;
        return 0;
    endfunction

    // Classifies the finished packet from the captured fields. The length
    // fields are zero whenever the packet is too short or of unknown version.
    function automatic pkt_result_t classify_packet(logic [15:0] len, logic high);
        pkt_result_t r;
        int unsigned n, hl, tl, thl;
        logic [3:0]  ver;
        ver   = hdr_fields.ver_ihl[7:4];
        n     = len;
        r     = '0;
        r.cls = CLS_BAD;
        if (n <= MIN_LEN_EXCL || (ver != VER_IPV4 && ver != VER_IPV6)) return r;
        hl = header_bytes(hdr_fields.ver_ihl);
        if (ver == VER_IPV4) tl = hdr_fields.len_field;
        else tl = (int'(hdr_fields.len_field) + V6_HDR_LEN) % 65536;
        thl       = {hdr_fields.tcp_off, 2'b00};
        r.hdr_len = hl;
        r.tot_len = tl;
        // The caller's priority mark beats every later check.
        if (high) begin
            r.cls = CLS_HIGH;
        end else if (n < tl || tl < hl) begin
            r.cls = CLS_BAD;
        end else if (hdr_fields.proto == PROTO_TCP) begin
            if (n < hl + TCP_MIN_HDR || n < hl + thl) r.cls = CLS_BAD;
            else if (tl == hl + thl) begin
                // Header-only segment: the flags decide.
                if (hdr_fields.tcp_flags[TCP_SYN_BIT]) r.cls = CLS_SYN;
                else if (hdr_fields.tcp_flags[TCP_ACK_BIT]) r.cls = CLS_ACK;
                else r.cls = CLS_TCP;
            end else if (hdr_fields.dst_port == ftp_port) r.cls = CLS_FTP;
            else r.cls = CLS_TCP;
        end else if (hdr_fields.proto == PROTO_UDP) begin
            // Mobile IP wins when its port equals the DNS port.
            if (n < hl + UDP_HDR || hdr_fields.udp_len < UDP_HDR) r.cls = CLS_BAD;
            else if (hdr_fields.dst_port == mip_port) r.cls = CLS_MIP;
            else if (hdr_fields.dst_port == dns_port) r.cls = CLS_DNS;
            else r.cls = CLS_UDP;
        end else if (hdr_fields.proto == PROTO_ICMP4) begin
            if (n < hl + ICMP_HDR) r.cls = CLS_BAD;
            else if (hdr_fields.frag != 0) r.cls = CLS_NONE;
            else if (hdr_fields.icmp_type == ICMP4_ECHO_REQ ||
                     hdr_fields.icmp_type == ICMP4_ECHO_REPLY) r.cls = CLS_ICMP;
            else r.cls = CLS_NONE;
        end else if (hdr_fields.proto == PROTO_ICMP6) begin
            if (n < hl + ICMP_HDR) r.cls = CLS_BAD;
            else if (hdr_fields.icmp_type == ICMP6_ECHO_REQ ||
                     hdr_fields.icmp_type == ICMP6_ECHO_REPLY) r.cls = CLS_ICMP;
            else r.cls = CLS_NONE;
        end else begin
            r.cls = CLS_NONE;
        end
        return r;
    endfunction

    // Applies one accepted byte to the capture state. A last byte queues the
    // expected record and clears the packet state.
    function automatic void track_byte(logic [7:0] b, logic last, logic high);
        int unsigned idx, hl;
        logic [7:0]  vb;
        idx = byte_cnt;
        vb  = (idx == 0) ? b : hdr_fields.ver_ihl;
        hl  = header_bytes(vb);
        if (idx == 0) hdr_fields.ver_ihl = b;
        if (vb[7:4] == VER_IPV4) begin
            if (idx == 2) hdr_fields.len_field[15:8] = b;
            if (idx == 3) hdr_fields.len_field[7:0]  = b;
            if (idx == 9) hdr_fields.proto           = b;
        end else if (vb[7:4] == VER_IPV6) begin
            if (idx == 4) hdr_fields.len_field[15:8] = b;
            if (idx == 5) hdr_fields.len_field[7:0]  = b;
            if (idx == 6) hdr_fields.proto           = b;
        end
        // The fragment offset always sits in bytes 6 and 7.
        if (idx == 6) hdr_fields.frag[12:8] = b[4:0];
        if (idx == 7) hdr_fields.frag[7:0]  = b;
        // Transport fields follow the header length, even when a small IHL
        // puts them on top of IP header bytes.
        if (vb[7:4] == VER_IPV4 || vb[7:4] == VER_IPV6) begin
            if (idx == hl)      hdr_fields.icmp_type      = b;
            if (idx == hl + 2)  hdr_fields.dst_port[15:8] = b;
            if (idx == hl + 3)  hdr_fields.dst_port[7:0]  = b;
            if (idx == hl + 4)  hdr_fields.udp_len[15:8]  = b;
            if (idx == hl + 5)  hdr_fields.udp_len[7:0]   = b;
            if (idx == hl + 12) hdr_fields.tcp_off        = b[7:4];
            if (idx == hl + 13) hdr_fields.tcp_flags      = b[5:0];
        end
        if (byte_cnt != COUNT_MAX) byte_cnt = byte_cnt + 16'd1;
        if (last) begin
            expected_class_q.push_back(classify_packet(byte_cnt, high));
            hdr_fields = '0;
            byte_cnt   = '0;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Packet construction.
    // ------------------------------------------------------------------------
    function automatic int desc_hdr_len(pkt_desc_t d);
        if (d.ver == VER_IPV6) return V6_HDR_LEN;
        if (d.ver == VER_IPV4) return d.ihl * 4;
        return 20;
    endfunction

    // A plain packet: IHL 5, minimum transport header plus the given payload.
    function automatic pkt_desc_t make_desc(logic [3:0] ver, logic [7:0] proto, int pay);
        pkt_desc_t d;
        d           = '0;
        d.ver       = ver;
        d.ihl       = 4'd5;
        d.proto     = proto;
        d.tcp_off   = 4'd5;
        d.dport     = $urandom;
        d.icmp_type = ICMP4_ECHO_REQ;
        d.n_bytes   = desc_hdr_len(d) + ((proto == PROTO_TCP) ? 20 : 8) + pay;
        d.udp_len   = d.n_bytes - desc_hdr_len(d);
        return d;
    endfunction

    function automatic void put_byte(int unsigned idx, logic [7:0] v);
        if (idx < pkt_buf.size()) pkt_buf[idx] = v;
    endfunction

    // Lays the described fields over random bytes and queues the result as
    // byte requests. The priority mark is random on all but the last byte.
    function automatic void queue_packet(pkt_desc_t d);
        int unsigned  hl;
        logic [15:0]  len16;
        logic [7:0]   rnd;
        stream_item_t it;
        hl = desc_hdr_len(d);
        pkt_buf.delete();
        for (int i = 0; i < d.n_bytes; i++) pkt_buf.push_back($urandom);
        put_byte(0, {d.ver, d.ihl});
        if (d.ver == VER_IPV6) begin
            len16 = d.n_bytes - V6_HDR_LEN + d.len_adj;
            put_byte(4, len16[15:8]);
            put_byte(5, len16[7:0]);
            put_byte(6, d.proto);
        end else begin
            len16 = d.n_bytes + d.len_adj;
            rnd   = $urandom;
            put_byte(2, len16[15:8]);
            put_byte(3, len16[7:0]);
            put_byte(6, {rnd[7:5], d.frag[12:8]});
            put_byte(7, d.frag[7:0]);
            put_byte(9, d.proto);
        end
        rnd = $urandom;
        put_byte(hl,      d.icmp_type);
        put_byte(hl + 2,  d.dport[15:8]);
        put_byte(hl + 3,  d.dport[7:0]);
        put_byte(hl + 4,  d.udp_len[15:8]);
        put_byte(hl + 5,  d.udp_len[7:0]);
        put_byte(hl + 12, {d.tcp_off, rnd[3:0]});
        put_byte(hl + 13, d.tcp_flags);
        for (int i = 0; i < pkt_buf.size(); i++) begin
            rnd     = $urandom;
            it.data = pkt_buf[i];
            it.last = (i == pkt_buf.size() - 1);
            it.high = it.last ? d.high : rnd[0];
            byte_stream_q.push_back(it);
        end
        packets_sent++;
        bytes_queued += pkt_buf.size();
    endfunction

    // Mostly well-formed IPv4/IPv6 packets with random content and a share
    // of broken lengths, odd header lengths and unknown versions.
    function automatic pkt_desc_t random_desc();
        pkt_desc_t   d;
        int unsigned pick, hl, tlen;
        logic [3:0]  ver, rnd4;
        logic [7:0]  proto;
        rnd4 = $urandom;
        pick = $urandom_range(99);
        if (pick < 8) ver = rnd4;
        else if (pick < 65) ver = VER_IPV4;
        else ver = VER_IPV6;
        pick = $urandom_range(99);
        if (pick < 35) proto = PROTO_TCP;
        else if (pick < 65) proto = PROTO_UDP;
        else if (pick < 80) proto = (ver == VER_IPV6) ? PROTO_ICMP6 : PROTO_ICMP4;
        else if (pick < 88) proto = (ver == VER_IPV6) ? PROTO_ICMP4 : PROTO_ICMP6;
        else proto = $urandom;
        d    = make_desc(ver, proto, 0);
        rnd4 = $urandom;
        if ($urandom_range(99) >= 70) d.ihl = rnd4;
        rnd4 = $urandom;
        if ($urandom_range(99) >= 60) d.tcp_off = rnd4;
        case ($urandom_range(3))
            0:       d.dport = ftp_port;
            1:       d.dport = dns_port;
            2:       d.dport = mip_port;
            default: d.dport = $urandom;
        endcase
        pick = $urandom_range(9);
        if (pick < 3) d.tcp_flags = 8'h02;
        else if (pick < 6) d.tcp_flags = 8'h10;
        else d.tcp_flags = $urandom;
        case ($urandom_range(4))
            0:       d.icmp_type = ICMP4_ECHO_REQ;
            1:       d.icmp_type = ICMP4_ECHO_REPLY;
            2:       d.icmp_type = ICMP6_ECHO_REQ;
            3:       d.icmp_type = ICMP6_ECHO_REPLY;
            default: d.icmp_type = $urandom;
        endcase
        if ($urandom_range(3) == 0) d.frag = $urandom;
        hl = desc_hdr_len(d);
        if (proto == PROTO_TCP) tlen = (d.tcp_off > 5) ? d.tcp_off * 4 : 20;
        else tlen = 8;
        d.n_bytes = hl + tlen + (($urandom_range(2) == 0) ? 0 : $urandom_range(1, 24));
        if ($urandom_range(9) == 0) d.n_bytes = $urandom_range(1, d.n_bytes);
        if ($urandom_range(9) < 8) d.udp_len = d.n_bytes - hl;
        else d.udp_len = $urandom_range(15);
        if ($urandom_range(9) < 8) d.len_adj = 0;
        else d.len_adj = int'($urandom_range(10)) - 5;
        d.high = ($urandom_range(99) < 8);
        return d;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: offers queued bytes, holds a request until it is taken, and
    // feeds every accepted byte to the class prediction.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : byte_driver
        stream_item_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                track_byte(s_tdata, s_tlast, s_tuser);
                bytes_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (byte_stream_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = byte_stream_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.data;
                    s_tlast  <= nxt.last;
                    s_tuser  <= nxt.high;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks each result request against the oldest expectation and
    // draws a fresh ready for the next cycle.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : result_monitor
        pkt_result_t want, got;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[25:0];
                if (expected_class_q.size() == 0) begin
                    $display("%0t: unexpected result: class %0d, header %0d, total %0d",
                             $time, got.cls, got.hdr_len, got.tot_len);
                    error_count++;
                end else begin
                    want = expected_class_q.pop_front();
                    results_checked++;
                    class_seen[got.cls]++;
                    if (got.cls != want.cls) begin
                        $display("%0t: packet_class mismatch: expected %0d, actual %0d",
                                 $time, want.cls, got.cls);
                        error_count++;
                    end
                    if (got.hdr_len != want.hdr_len) begin
                        $display("%0t: ip_header_len mismatch: expected %0d, actual %0d",
                                 $time, want.hdr_len, got.hdr_len);
                        error_count++;
                    end
                    if (got.tot_len != want.tot_len) begin
                        $display("%0t: ip_total_len mismatch: expected %0d, actual %0d",
                                 $time, want.tot_len, got.tot_len);
                        error_count++;
                    end
                end
            end
            m_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Back-pressure: once triggered, the receiver refuses results for a long
    // stretch. The sender keeps offering bytes, so both parser stages fill
    // and s_tready has to drop.
    // ------------------------------------------------------------------------
    initial begin : output_hold_off
        wait (pressure_go);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge aclk);
        hold_off <= 1'b0;
    end

    // Writes one port register and mirrors it into the local copy.
    task automatic write_port_reg(logic [1:0] idx, logic [15:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_FTP_PORT: ftp_port = val;
            REG_DNS_PORT: dns_port = val;
            REG_MIP_PORT: mip_port = val;
            default: ;
        endcase
    endtask

    // Waits until every byte is taken and every result has been checked, then
    // lets the parser's two stages drain.
    task automatic wait_idle();
        while (byte_stream_q.size() != 0 || s_tvalid || expected_class_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus sequence.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        pkt_desc_t   d;
        int unsigned phase_start, phase_pkts;
        string       cls_line;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed packets at the reset port values, with no idling.
        // A one-byte packet and a 20-byte packet are both too short.
        d = make_desc(VER_IPV4, PROTO_UDP, 0);
        d.n_bytes = 1;
        d.high    = 1'b1;
        queue_packet(d);
        d.n_bytes = 20;
        queue_packet(d);
        // Unknown version nibbles.
        d = make_desc(4'h0, PROTO_TCP, 10);
        queue_packet(d);
        d.ver = 4'hF;
        queue_packet(d);
        // Header-only TCP segments: SYN, ACK, no flags, all flags.
        d = make_desc(VER_IPV4, PROTO_TCP, 0);
        d.tcp_flags = 8'h02;
        queue_packet(d);
        d.tcp_flags = 8'h10;
        queue_packet(d);
        d.tcp_flags = 8'hC0;
        queue_packet(d);
        d.tcp_flags = 8'hFF;
        queue_packet(d);
        // TCP with payload, to the FTP port and elsewhere.
        d = make_desc(VER_IPV4, PROTO_TCP, 12);
        d.dport = FTP_PORT_RST;
        queue_packet(d);
        d.dport = 16'hFFFF;
        queue_packet(d);
        // UDP: DNS, mobile IP, and a UDP length below the header size.
        d = make_desc(VER_IPV4, PROTO_UDP, 5);
        d.dport = DNS_PORT_RST;
        queue_packet(d);
        d.dport = MIP_PORT_RST;
        queue_packet(d);
        d.udp_len = 16'd7;
        queue_packet(d);
        // ICMPv4: echo reply, an unlisted type, and a nonzero fragment offset.
        d = make_desc(VER_IPV4, PROTO_ICMP4, 4);
        d.icmp_type = ICMP4_ECHO_REPLY;
        queue_packet(d);
        d.icmp_type = 8'd3;
        queue_packet(d);
        d.icmp_type = ICMP4_ECHO_REQ;
        d.frag      = 13'h1FFF;
        queue_packet(d);
        // IPv6: ICMPv6 echo, and ICMPv4 dispatched on the protocol alone.
        d = make_desc(VER_IPV6, PROTO_ICMP6, 0);
        d.icmp_type = ICMP6_ECHO_REPLY;
        queue_packet(d);
        d.proto     = PROTO_ICMP4;
        d.icmp_type = ICMP4_ECHO_REQ;
        queue_packet(d);
        // Priority mark on a packet whose lengths disagree.
        d = make_desc(VER_IPV4, PROTO_UDP, 3);
        d.len_adj = 3;
        d.high    = 1'b1;
        queue_packet(d);
        // Total length beyond the packet, and below the header length.
        d = make_desc(VER_IPV4, PROTO_TCP, 6);
        d.len_adj = 1;
        queue_packet(d);
        d.ihl     = 4'd15;
        d.n_bytes = 80;
        d.len_adj = -70;
        queue_packet(d);
        // IHL of zero puts the transport fields over the IP header.
        d = make_desc(VER_IPV4, PROTO_TCP, 0);
        d.ihl     = 4'd0;
        d.n_bytes = 40;
        queue_packet(d);
        // Unhandled protocol.
        d = make_desc(VER_IPV4, 8'hFF, 0);
        queue_packet(d);
        // IPv6 payload length that wraps the 16-bit total length.
        d = make_desc(VER_IPV6, PROTO_UDP, 0);
        d.len_adj = 16'hFFE0 - 8;
        queue_packet(d);
        wait_idle();

        // Random phases, each with its own port settings and idle mix.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 0;  recv_stall_pct = 0;
                    write_port_reg(REG_FTP_PORT, 16'h0000);
                    write_port_reg(REG_DNS_PORT, 16'h0000);
                    write_port_reg(REG_MIP_PORT, 16'h0000);
                end
                1: begin
                    send_idle_pct = 55; recv_stall_pct = 0;
                    write_port_reg(REG_FTP_PORT, 16'hFFFF);
                    write_port_reg(REG_DNS_PORT, 16'hFFFF);
                    write_port_reg(REG_MIP_PORT, 16'hFFFF);
                end
                2: begin
                    send_idle_pct = 0;  recv_stall_pct = 55;
                    write_port_reg(REG_FTP_PORT, $urandom);
                    write_port_reg(REG_DNS_PORT, $urandom);
                    write_port_reg(REG_MIP_PORT, $urandom);
                end
                default: begin
                    send_idle_pct = 37; recv_stall_pct = 37;
                    write_port_reg(REG_FTP_PORT, FTP_PORT_RST);
                    write_port_reg(REG_DNS_PORT, DNS_PORT_RST);
                    write_port_reg(REG_MIP_PORT, MIP_PORT_RST);
                end
            endcase
            // The long output stall lands in the phase with a busy sender.
            if (ph == 0) pressure_go = 1'b1;
            phase_start = bytes_queued;
            phase_pkts  = 0;
            while (bytes_queued - phase_start < 40 || phase_pkts < 3) begin
                queue_packet(random_desc());
                phase_pkts++;
            end
            wait_idle();
        end

        if (expected_class_q.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, expected_class_q.size());
            error_count++;
        end
        cls_line = "";
        for (int i = 0; i <= CLS_BAD; i++) cls_line = {cls_line, $sformatf(" %0d", class_seen[i])};
        $display("Sent %0d packets (%0d bytes) under five port settings and four idle mixes,",
                 packets_sent, bytes_accepted);
        $display("with a long output stall; results per class:%s",
                 cls_line);
        if (error_count == 0) begin
            $display("ip_packet_class_parser_tb: done, clean");
        end else begin
            $display("ip_packet_class_parser_tb: done, errors");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin : watchdog
        #5ms;
        $display("%0t: run did not complete in time", $time);
        $display("ip_packet_class_parser_tb: done, errors");
        $finish;
    end

endmodule
